### src/dre_pkg.sv
package dre_pkg;

    // Parser phase, one-hot.
    typedef enum logic [10:0] {
        PH_HDR    = 11'b000_0000_0001,
        PH_QNAME  = 11'b000_0000_0010,
        PH_QPTR   = 11'b000_0000_0100,
        PH_QFIX   = 11'b000_0000_1000,
        PH_ASTART = 11'b000_0001_0000,
        PH_ANAME  = 11'b000_0010_0000,
        PH_APTR   = 11'b000_0100_0000,
        PH_AFIX   = 11'b000_1000_0000,
        PH_AADDR  = 11'b001_0000_0000,
        PH_ASKIP  = 11'b010_0000_0000,
        PH_DONE   = 11'b100_0000_0000
    } phase_t;

    // Result codes; the last one only marks a verdict not yet reached.
    typedef enum logic [2:0] {
        ST_FOUND      = 3'd0,
        ST_SHORT      = 3'd1,
        ST_WRONG_ID   = 3'd2,
        ST_NOT_REPLY  = 3'd3,
        ST_SERVER_ERR = 3'd4,
        ST_NO_ADDR    = 3'd5,
        ST_MALFORMED  = 3'd6,
        ST_UNDECIDED  = 3'd7
    } status_t;

    localparam logic [3:0] HDR_LAST_IDX   = 4'd11;
    localparam logic [3:0] QFIX_LAST_IDX  = 4'd3;
    localparam logic [3:0] AFIX_LAST_IDX  = 4'd9;
    localparam logic [3:0] AADDR_LAST_IDX = 4'd3;
    localparam logic [7:0] PTR_MASK       = 8'hC0;
    localparam logic [15:0] TYPE_A        = 16'd1;
    localparam logic [15:0] RDLEN_A       = 16'd4;

    typedef struct packed {
        phase_t      phase;
        logic [3:0]  header_index;
        logic [15:0] reply_id;
        logic [15:0] reply_flags;
        logic [15:0] questions_left;
        logic [15:0] answers_left;
        logic [15:0] skip_left;
        logic [3:0]  record_index;
        logic [15:0] record_type;
        logic [15:0] record_length;
        logic [31:0] address_acc;
        status_t     verdict;
    } parse_state_t;

    localparam parse_state_t PARSE_CLEAR = '{
        phase:          PH_HDR,
        header_index:   4'd0,
        reply_id:       16'd0,
        reply_flags:    16'd0,
        questions_left: 16'd0,
        answers_left:   16'd0,
        skip_left:      16'd0,
        record_index:   4'd0,
        record_type:    16'd0,
        record_length:  16'd0,
        address_acc:    32'd0,
        verdict:        ST_UNDECIDED
    };

    typedef struct packed {
        status_t     status;
        logic [31:0] address;
    } result_t;

endpackage

### src/dre_parser.sv
module dre_parser (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             go,
    input  logic [7:0]       data_byte,
    input  logic             data_last,
    input  logic [15:0]      expected_id,
    output logic             res_valid,
    output dre_pkg::result_t res
);
    import dre_pkg::*;

    parse_state_t st_reg;
    parse_state_t st_next;
    parse_state_t st_upd;
    status_t      fin_status;

    function automatic parse_state_t next_answer(parse_state_t s);
        parse_state_t r;
        r = s;
        if (s.answers_left != 16'd0)
        begin
            r.answers_left = s.answers_left - 16'd1;
            r.skip_left    = 16'd0;
            r.phase        = PH_ASTART;
        end
        else
        begin
            r.verdict = ST_NO_ADDR;
            r.phase   = PH_DONE;
        end
        return r;
    endfunction

    function automatic parse_state_t next_question(parse_state_t s);
        parse_state_t r;
        r = s;
        if (s.questions_left != 16'd0)
        begin
            r.questions_left = s.questions_left - 16'd1;
            r.skip_left      = 16'd0;
            r.phase          = PH_QNAME;
        end
        else
        begin
            r = next_answer(s);
        end
        return r;
    endfunction

    // One byte at a name position: label length, label body, end or pointer.
    function automatic parse_state_t name_byte(parse_state_t s, logic [7:0] b,
                                               phase_t name_ph, phase_t ptr_ph,
                                               phase_t fix_ph);
        parse_state_t r;
        r = s;
        if (s.skip_left != 16'd0)
        begin
            r.skip_left = s.skip_left - 16'd1;
            r.phase     = name_ph;
        end
        else if (b == 8'd0)
        begin
            r.record_index = 4'd0;
            r.phase        = fix_ph;
        end
        else if ((b & PTR_MASK) == PTR_MASK)
        begin
            r.phase = ptr_ph;
        end
        else
        begin
            r.skip_left = {8'd0, b};
            r.phase     = name_ph;
        end
        return r;
    endfunction

    always_comb
    begin
        st_upd = st_reg;
        unique case (st_reg.phase)
            PH_HDR:
            begin
                unique case (st_reg.header_index)
                    4'd0: st_upd.reply_id[15:8]       = data_byte;
                    4'd1: st_upd.reply_id[7:0]        = data_byte;
                    4'd2: st_upd.reply_flags[15:8]    = data_byte;
                    4'd3: st_upd.reply_flags[7:0]     = data_byte;
                    4'd4: st_upd.questions_left[15:8] = data_byte;
                    4'd5: st_upd.questions_left[7:0]  = data_byte;
                    4'd6: st_upd.answers_left[15:8]   = data_byte;
                    4'd7: st_upd.answers_left[7:0]    = data_byte;
                    default: ;
                endcase
                st_upd.header_index = st_reg.header_index + 4'd1;
                if (st_reg.header_index == HDR_LAST_IDX)
                begin
                    // Header complete: id first, then QR, then RCODE.
                    if (st_reg.reply_id != expected_id)
                    begin
                        st_upd.verdict = ST_WRONG_ID;
                        st_upd.phase   = PH_DONE;
                    end
                    else if (!st_reg.reply_flags[15])
                    begin
                        st_upd.verdict = ST_NOT_REPLY;
                        st_upd.phase   = PH_DONE;
                    end
                    else if (st_reg.reply_flags[3:0] != 4'd0)
                    begin
                        st_upd.verdict = ST_SERVER_ERR;
                        st_upd.phase   = PH_DONE;
                    end
                    else
                    begin
                        st_upd = next_question(st_upd);
                    end
                end
            end
            PH_QNAME:
                st_upd = name_byte(st_reg, data_byte, PH_QNAME, PH_QPTR, PH_QFIX);
            PH_QPTR:
            begin
                st_upd.record_index = 4'd0;
                st_upd.phase        = PH_QFIX;
            end
            PH_QFIX:
            begin
                st_upd.record_index = st_reg.record_index + 4'd1;
                if (st_reg.record_index == QFIX_LAST_IDX)
                    st_upd = next_question(st_upd);
            end
            PH_ASTART, PH_ANAME:
                st_upd = name_byte(st_reg, data_byte, PH_ANAME, PH_APTR, PH_AFIX);
            PH_APTR:
            begin
                st_upd.record_index = 4'd0;
                st_upd.phase        = PH_AFIX;
            end
            PH_AFIX:
            begin
                unique case (st_reg.record_index)
                    4'd0:          st_upd.record_type[15:8]   = data_byte;
                    4'd1:          st_upd.record_type[7:0]    = data_byte;
                    4'd8:          st_upd.record_length[15:8] = data_byte;
                    AFIX_LAST_IDX: st_upd.record_length[7:0]  = data_byte;
                    default: ;
                endcase
                st_upd.record_index = st_reg.record_index + 4'd1;
                if (st_reg.record_index == AFIX_LAST_IDX)
                begin
                    if (st_upd.record_type == TYPE_A && st_upd.record_length == RDLEN_A)
                    begin
                        st_upd.record_index = 4'd0;
                        st_upd.address_acc  = 32'd0;
                        st_upd.phase        = PH_AADDR;
                    end
                    else if (st_upd.record_length == 16'd0)
                    begin
                        st_upd = next_answer(st_upd);
                    end
                    else
                    begin
                        st_upd.skip_left = st_upd.record_length;
                        st_upd.phase     = PH_ASKIP;
                    end
                end
            end
            PH_AADDR:
            begin
                st_upd.address_acc  = {st_reg.address_acc[23:0], data_byte};
                st_upd.record_index = st_reg.record_index + 4'd1;
                if (st_reg.record_index == AADDR_LAST_IDX)
                begin
                    st_upd.verdict = ST_FOUND;
                    st_upd.phase   = PH_DONE;
                end
            end
            PH_ASKIP:
            begin
                if (st_reg.skip_left != 16'd0)
                    st_upd.skip_left = st_reg.skip_left - 16'd1;
                if (st_upd.skip_left == 16'd0)
                    st_upd = next_answer(st_upd);
            end
            PH_DONE: ;
            default: ;
        endcase
    end

    // Status of a reply that ends right after this byte.
    always_comb
    begin
        unique case (st_upd.phase)
            PH_HDR:            fin_status = ST_SHORT;
            PH_QNAME:          fin_status = ST_MALFORMED;
            PH_QPTR, PH_QFIX:  fin_status = (st_upd.questions_left != 16'd0) ?
                                            ST_MALFORMED : ST_NO_ADDR;
            PH_ASTART, PH_ASKIP: fin_status = ST_NO_ADDR;
            PH_DONE:           fin_status = st_upd.verdict;
            default:           fin_status = ST_MALFORMED;
        endcase
    end

    always_comb
    begin
        st_next = st_reg;
        if (go)
            st_next = data_last ? PARSE_CLEAR : st_upd;
    end

    assign res_valid       = go && data_last;
    assign res.status      = fin_status;
    assign res.address     = (fin_status == ST_FOUND) ? st_upd.address_acc : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            st_reg <= PARSE_CLEAR;
        else
            st_reg <= st_next;
    end

    // A verdict is held only once the parser has stopped on this reply.
    a_verdict_done: assert property (@(posedge clk) disable iff (!rst_n)
        (st_reg.phase != PH_DONE) |-> (st_reg.verdict == ST_UNDECIDED))
        else $error("verdict set outside the done phase");

    // The header counter never runs past the twelfth byte.
    a_hdr_idx: assert property (@(posedge clk) disable iff (!rst_n)
        (st_reg.phase == PH_HDR) |-> (st_reg.header_index <= HDR_LAST_IDX))
        else $error("header index out of range");

    // The last byte of a reply returns the parser to the header phase.
    a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (go && data_last) |=> (st_reg.phase == PH_HDR && st_reg.header_index == 4'd0))
        else $error("parser not cleared after the last byte");

endmodule

### src/dre_out_fifo.sv
module dre_out_fifo (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  dre_pkg::result_t push_data,
    output logic             full,
    output logic             pop_valid,
    input  logic             pop_stall,
    output dre_pkg::result_t pop_data
);
    import dre_pkg::*;

    result_t    mem [2];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] count_reg;
    logic [1:0] count_next;
    logic       pop;

    assign full      = (count_reg == 2'd2);
    assign pop_valid = (count_reg != 2'd0);
    assign pop       = pop_valid && !pop_stall;
    assign pop_data  = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= push_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !full)
        else $error("result pushed into a full buffer");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg != 2'd3)
        else $error("result buffer count out of range");

    a_ptr_track: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == 2'd0 || count_reg == 2'd2) |-> (wr_ptr_reg == rd_ptr_reg))
        else $error("buffer pointers disagree with count");

endmodule

### src/dns_response_address_extractor.sv
// DNS reply address extractor.
//
// The reply enters one byte per word on the input channel (payload_byte,
// last_byte, in_valid, in_stall); a word is taken at a clock edge with
// in_valid high and in_stall low. The 12-byte header is checked against the
// expected transaction id, the QR bit and RCODE, the questions are skipped,
// and the answers are scanned for the first type-A record with 4-byte rdata.
// The word with last_byte set closes the reply and yields exactly one result
// word (status, address) on the output channel, taken when out_valid is high
// and out_stall low. Other words yield nothing.
//
// Each byte is held in the input register and parsed from there when the
// result buffer has room; parsing a last byte writes its result word into
// the buffer, which feeds the output channel. One byte per cycle is sustained
// while the buffer has room: the parse of one byte is a single state update,
// and a two-word result buffer lets parsing go on while the receiver holds
// a result. in_stall rises only when that buffer is full with a byte waiting.
// expected_id is written through cfg_valid/cfg_ready, which is always ready.
// Reset clears the parser, the buffer and expected_id.
module dns_response_address_extractor (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  payload_byte,
    input  logic        last_byte,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [2:0]  status,
    output logic [31:0] address,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [15:0] expected_id
);
    import dre_pkg::*;

    // Input register holding one byte word.
    logic        in_v_reg;
    logic        in_v_next;
    logic [7:0]  byte_reg;
    logic        last_reg;
    logic [15:0] exp_id_reg;
    logic        in_take;
    logic        parse_go;
    logic        buf_full;
    logic        res_valid;
    result_t     res;
    result_t     out_data;

    // The parser runs whenever a byte is held and the result buffer has room.
    assign parse_go  = in_v_reg && !buf_full;
    assign in_stall  = in_v_reg && buf_full;
    assign in_take   = in_valid && !in_stall;
    assign cfg_ready = 1'b1;

    always_comb
    begin
        if (in_take)
            in_v_next = 1'b1;
        else if (parse_go)
            in_v_next = 1'b0;
        else
            in_v_next = in_v_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_v_reg   <= 1'b0;
            exp_id_reg <= 16'd0;
        end
        else
        begin
            in_v_reg <= in_v_next;
            if (cfg_valid && cfg_ready)
                exp_id_reg <= expected_id;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            byte_reg <= payload_byte;
            last_reg <= last_byte;
        end
    end

    dre_parser u_parser (
        .clk         (clk),
        .rst_n       (rst_n),
        .go          (parse_go),
        .data_byte   (byte_reg),
        .data_last   (last_reg),
        .expected_id (exp_id_reg),
        .res_valid   (res_valid),
        .res         (res)
    );

    dre_out_fifo u_out_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (res_valid),
        .push_data (res),
        .full      (buf_full),
        .pop_valid (out_valid),
        .pop_stall (out_stall),
        .pop_data  (out_data)
    );

    assign status  = out_data.status;
    assign address = out_data.address;

endmodule

### tb/dns_reply_monitor.sv
module dns_reply_monitor (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_stall,
    input  logic [7:0]  payload_byte,
    input  logic        last_byte,
    input  logic        out_valid,
    input  logic        out_stall,
    input  logic [2:0]  status,
    input  logic [31:0] address,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [15:0] expected_id,
    output int          owed_results,
    output int          mismatch_count
);
    import dre_pkg::*;

    localparam logic [3:0]  HDR_BYTES  = 4'd12;
    localparam logic [3:0]  QFIX_BYTES = 4'd4;
    localparam logic [3:0]  AFIX_BYTES = 4'd10;
    localparam logic [3:0]  ADDR_BYTES = 4'd4;
    localparam logic [7:0]  PTR_TAG    = 8'hC0;
    localparam logic [15:0] RR_TYPE_A  = 16'd1;
    localparam logic [15:0] RR_LEN_A   = 16'd4;

    // Shadow of the parser state.
    phase_t      stage;
    logic [3:0]  hdr_pos;
    logic [15:0] rx_id;
    logic [15:0] rx_flags;
    logic [15:0] quest_left;
    logic [15:0] ans_left;
    logic [15:0] skip_cnt;
    logic [3:0]  rr_pos;
    logic [15:0] rr_type;
    logic [15:0] rr_len;
    logic [31:0] addr_acc;
    status_t     verdict;
    logic [15:0] want_id;

    result_t     owed_q[$];
    result_t     head;
    int          mismatches;

    task automatic restart_parse();
        stage      = PH_HDR;
        hdr_pos    = '0;
        rx_id      = '0;
        rx_flags   = '0;
        quest_left = '0;
        ans_left   = '0;
        skip_cnt   = '0;
        rr_pos     = '0;
        rr_type    = '0;
        rr_len     = '0;
        addr_acc   = '0;
        verdict    = ST_UNDECIDED;
    endtask

    task automatic settle(input status_t v);
        verdict = v;
        stage   = PH_DONE;
    endtask

    task automatic open_answer();
        if (ans_left != 16'd0)
        begin
            ans_left = ans_left - 16'd1;
            skip_cnt = '0;
            stage    = PH_ASTART;
        end
        else
        begin
            settle(ST_NO_ADDR);
        end
    endtask

    task automatic open_question();
        if (quest_left != 16'd0)
        begin
            quest_left = quest_left - 16'd1;
            skip_cnt   = '0;
            stage      = PH_QNAME;
        end
        else
        begin
            open_answer();
        end
    endtask

    // One byte of a name: label body, label length, terminator or pointer.
    task automatic name_step(input logic [7:0] b, input phase_t ptr_stage,
                             input phase_t label_stage, output bit ended);
        ended = 1'b0;
        if (skip_cnt != 16'd0)
        begin
            skip_cnt = skip_cnt - 16'd1;
            stage    = label_stage;
        end
        else if (b == 8'd0)
        begin
            ended = 1'b1;
        end
        else if ((b & PTR_TAG) == PTR_TAG)
        begin
            stage = ptr_stage;
        end
        else
        begin
            skip_cnt = {8'd0, b};
            stage    = label_stage;
        end
    endtask

    task automatic header_step(input logic [7:0] b);
        unique case (hdr_pos)
            4'd0: rx_id = {b, 8'd0};
            4'd1: rx_id[7:0] = b;
            4'd2: rx_flags = {b, 8'd0};
            4'd3: rx_flags[7:0] = b;
            4'd4: quest_left = {b, 8'd0};
            4'd5: quest_left[7:0] = b;
            4'd6: ans_left = {b, 8'd0};
            4'd7: ans_left[7:0] = b;
            default: ;
        endcase
        hdr_pos = hdr_pos + 4'd1;
        if (hdr_pos == HDR_BYTES)
        begin
            if (rx_id != want_id)
                settle(ST_WRONG_ID);
            else if (!rx_flags[15])
                settle(ST_NOT_REPLY);
            else if (rx_flags[3:0] != 4'd0)
                settle(ST_SERVER_ERR);
            else
                open_question();
        end
    endtask

    task automatic parse_byte(input logic [7:0] b);
        bit ended;
        unique case (stage)
            PH_HDR: header_step(b);
            PH_QNAME:
            begin
                name_step(b, PH_QPTR, PH_QNAME, ended);
                if (ended)
                begin
                    rr_pos = '0;
                    stage  = PH_QFIX;
                end
            end
            PH_QPTR:
            begin
                rr_pos = '0;
                stage  = PH_QFIX;
            end
            PH_QFIX:
            begin
                rr_pos = rr_pos + 4'd1;
                if (rr_pos >= QFIX_BYTES)
                    open_question();
            end
            PH_ASTART, PH_ANAME:
            begin
                name_step(b, PH_APTR, PH_ANAME, ended);
                if (ended)
                begin
                    rr_pos = '0;
                    stage  = PH_AFIX;
                end
            end
            PH_APTR:
            begin
                rr_pos = '0;
                stage  = PH_AFIX;
            end
            PH_AFIX:
            begin
                unique case (rr_pos)
                    4'd0: rr_type = {b, 8'd0};
                    4'd1: rr_type[7:0] = b;
                    4'd8: rr_len = {b, 8'd0};
                    4'd9: rr_len[7:0] = b;
                    default: ;
                endcase
                rr_pos = rr_pos + 4'd1;
                if (rr_pos >= AFIX_BYTES)
                begin
                    if (rr_type == RR_TYPE_A && rr_len == RR_LEN_A)
                    begin
                        rr_pos   = '0;
                        addr_acc = '0;
                        stage    = PH_AADDR;
                    end
                    else if (rr_len == 16'd0)
                    begin
                        open_answer();
                    end
                    else
                    begin
                        skip_cnt = rr_len;
                        stage    = PH_ASKIP;
                    end
                end
            end
            PH_AADDR:
            begin
                addr_acc = {addr_acc[23:0], b};
                rr_pos   = rr_pos + 4'd1;
                if (rr_pos >= ADDR_BYTES)
                    settle(ST_FOUND);
            end
            PH_ASKIP:
            begin
                if (skip_cnt != 16'd0)
                    skip_cnt = skip_cnt - 16'd1;
                if (skip_cnt == 16'd0)
                    open_answer();
            end
            default: ;
        endcase
    endtask

    // Status of a reply that ends where the parser now stands.
    function automatic status_t closing_status();
        unique case (stage)
            PH_HDR:            return ST_SHORT;
            PH_QNAME:          return ST_MALFORMED;
            PH_QPTR, PH_QFIX:  return (quest_left != 16'd0) ? ST_MALFORMED : ST_NO_ADDR;
            PH_ASTART, PH_ASKIP: return ST_NO_ADDR;
            PH_DONE:           return verdict;
            default:           return ST_MALFORMED;
        endcase
    endfunction

    task automatic absorb_word(input logic [7:0] b, input logic last);
        result_t r;
        parse_byte(b);
        if (last)
        begin
            r.status  = closing_status();
            r.address = (r.status == ST_FOUND) ? addr_acc : 32'd0;
            owed_q.push_back(r);
            restart_parse();
        end
    endtask

    task automatic flag(input string what, input logic [31:0] got, input logic [31:0] want);
        $display("MISMATCH at %0t: %s, got 0x%0h, expected 0x%0h", $realtime, what, got, want);
        mismatches++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            want_id = '0;
            restart_parse();
            owed_q.delete();
            mismatches = 0;
            owed_results   <= 0;
            mismatch_count <= 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (owed_q.size() == 0)
                begin
                    flag("result word with no reply outstanding", {29'd0, status}, 32'd0);
                end
                else
                begin
                    head = owed_q.pop_front();
                    if (status !== head.status)
                        flag("status", {29'd0, status}, {29'd0, head.status});
                    if (address !== head.address)
                        flag("address", address, head.address);
                end
            end
            if (cfg_valid && cfg_ready)
                want_id = expected_id;
            if (in_valid && !in_stall)
                absorb_word(payload_byte, last_byte);
            owed_results   <= owed_q.size();
            mismatch_count <= mismatches;
        end
    end

endmodule

### tb/tb.sv
// Stimulus and verdict for the DNS reply address extractor.
//
// Replies are built byte by byte in a message queue and then streamed into the
// block, one byte per word. The monitor beside the block keeps its own parser
// and compares every result word; this module only drives the channels,
// changes the expected transaction id between phases, and reports the outcome.
module tb;
    import dre_pkg::*;

    // Record types used when building answers.
    localparam logic [15:0] A_RECORD     = 16'd1;
    localparam logic [15:0] CNAME_RECORD = 16'd5;
    localparam logic [15:0] AAAA_RECORD  = 16'd28;

    // Typical reply flags (QR, RD, RA set, RCODE clear) and the bare QR bit.
    localparam logic [15:0] REPLY_FLAGS = 16'h8180;
    localparam logic [15:0] QR_ONLY     = 16'h8000;

    // The receiver's long hold-off, and the watchdog limit on cycles with no
    // word moving on any channel. The limit covers the hold-off many times.
    localparam int HOLD_CYCLES = 400;
    localparam int QUIET_LIMIT = 4000;

    // Size of one random phase in bytes; six phases give the bulk of the run.
    localparam int PHASE_BYTES = 215;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [7:0]  payload_byte = 8'd0;
    logic        last_byte = 1'b0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [2:0]  status;
    logic [31:0] address;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [15:0] expected_id = 16'd0;

    int          owed_results;
    int          mismatch_count;

    // Reply under construction, and bookkeeping for the stimulus.
    logic [7:0]  msg[$];
    int          sent = 0;
    int          send_pct = 0;
    int          stall_pct = 0;
    logic [15:0] id_now = 16'd0;
    bit          squeeze_go = 1'b0;
    logic        hold_rx = 1'b0;
    int          quiet = 0;

    dns_response_address_extractor dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .payload_byte (payload_byte),
        .last_byte    (last_byte),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .status       (status),
        .address      (address),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .expected_id  (expected_id)
    );

    dns_reply_monitor reply_check (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .payload_byte   (payload_byte),
        .last_byte      (last_byte),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .status         (status),
        .address        (address),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .expected_id    (expected_id),
        .owed_results   (owed_results),
        .mismatch_count (mismatch_count)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // The receiver stalls at random, and solidly while the hold-off is on.
    always @(posedge clk)
    begin
        out_stall <= hold_rx || ($urandom_range(99) < stall_pct);
    end

    // Long hold-off on the result side. The sender keeps offering words in the
    // meantime, so the result buffer fills and the block must stall its input.
    initial
    begin
        wait (squeeze_go);
        @(posedge clk);
        hold_rx <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_rx <= 1'b0;
    end

    // Watchdog: a run in which no word moves for too long is a failure.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
            begin
                quiet <= 0;
            end
            else if (quiet >= QUIET_LIMIT)
            begin
                $display("end of test: mismatches");
                $finish;
            end
            else
            begin
                quiet <= quiet + 1;
            end
        end
    end

    // Offers one byte word, after a random number of idle cycles, and returns
    // in the time step of the edge that took it. Valid stays high from one
    // word to the next unless an idle cycle is drawn.
    task automatic send_word(input logic [7:0] b, input logic last);
        while ($urandom_range(99) < send_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid     <= 1'b1;
        payload_byte <= b;
        last_byte    <= last;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    // Streams the first keep bytes of the message (all of it when keep is zero
    // or too large), marking the final one as last, and empties the message.
    task automatic ship(input int keep);
        int n;
        n = (keep <= 0 || keep > msg.size()) ? msg.size() : keep;
        for (int k = 0; k < n; k++)
            send_word(msg[k], k == n - 1);
        sent += n;
        msg.delete();
    endtask

    // Writes the expected id. The block must be idle: every result has come
    // back, and a few more cycles cover a byte still in the input register.
    task automatic write_id(input logic [15:0] v);
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (owed_results != 0);
        repeat (6) @(posedge clk);
        cfg_valid   <= 1'b1;
        expected_id <= v;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        id_now = v;
    endtask

    task automatic put_random(input int n);
        repeat (n) msg.push_back(8'($urandom));
    endtask

    // Header: id, flags, question and answer counts, then four random bytes
    // for the authority and additional counts, which the block ignores.
    task automatic put_header(input logic [15:0] id, input logic [15:0] flags,
                              input logic [15:0] qd, input logic [15:0] an);
        msg.push_back(id[15:8]);
        msg.push_back(id[7:0]);
        msg.push_back(flags[15:8]);
        msg.push_back(flags[7:0]);
        msg.push_back(qd[15:8]);
        msg.push_back(qd[7:0]);
        msg.push_back(an[15:8]);
        msg.push_back(an[7:0]);
        put_random(4);
    endtask

    task automatic put_label(input int len);
        msg.push_back(8'(len));
        put_random(len);
    endtask

    // Compression pointer: both top bits set, then an offset byte.
    task automatic put_ptr();
        msg.push_back({2'b11, 6'($urandom)});
        msg.push_back(8'($urandom));
    endtask

    // Fixed part of an answer record: type, random class and TTL, rdlength.
    task automatic put_rr(input logic [15:0] rtype, input logic [15:0] rdlen);
        msg.push_back(rtype[15:8]);
        msg.push_back(rtype[7:0]);
        put_random(6);
        msg.push_back(rdlen[15:8]);
        msg.push_back(rdlen[7:0]);
    endtask

    task automatic put_address(input logic [31:0] a);
        msg.push_back(a[31:24]);
        msg.push_back(a[23:16]);
        msg.push_back(a[15:8]);
        msg.push_back(a[7:0]);
    endtask

    // A name of zero to three short labels, ended by a zero byte or by a
    // pointer. Now and then a length byte with top bits 01 or 10 appears,
    // which the block takes as a long plain label.
    task automatic random_name();
        int n;
        n = $urandom_range(3);
        repeat (n)
        begin
            if ($urandom_range(19) == 0)
                msg.push_back(8'($urandom_range(64, 191)));
            else
                put_label($urandom_range(1, 6));
        end
        if ($urandom_range(99) < 30)
            put_ptr();
        else
            msg.push_back(8'd0);
    endtask

    // One answer record: proper A records two times in five, otherwise ones
    // the block must skip, including empty rdata and an rdlength far too long.
    task automatic random_record();
        int roll;
        int len;
        roll = $urandom_range(99);
        if (roll < 40)
        begin
            put_rr(A_RECORD, 16'd4);
            put_random(4);
        end
        else if (roll < 50)
        begin
            len = $urandom_range(6);
            put_rr(A_RECORD, 16'(len));
            put_random(len);
        end
        else if (roll < 58)
        begin
            put_rr({8'($urandom_range(1, 255)), 8'd1}, 16'd4);
            put_random(4);
        end
        else if (roll < 66)
        begin
            put_rr(16'($urandom), 16'd0);
        end
        else if (roll < 70)
        begin
            put_rr(16'($urandom), 16'($urandom_range(9, 65535)));
        end
        else
        begin
            len = $urandom_range(1, 8);
            put_rr(($urandom_range(1) == 0) ? CNAME_RECORD : AAAA_RECORD, 16'(len));
            put_random(len);
        end
    endtask

    // One random reply. Many are well formed with random content; the rest
    // are noise, carry a wrong id or bad flags, claim huge counts, have
    // trailing bytes, or are cut short at a random point.
    task automatic random_reply();
        logic [15:0] rid;
        logic [15:0] flags;
        int          qd;
        int          an;
        int          cut;
        if ($urandom_range(99) < 8)
        begin
            put_random($urandom_range(1, 30));
            ship(0);
        end
        else
        begin
            rid   = ($urandom_range(9) == 0) ? 16'($urandom) : id_now;
            flags = 16'($urandom);
            if ($urandom_range(99) < 85)
                flags = {1'b1, flags[14:4], 4'h0};
            qd = ($urandom_range(29) == 0) ? $urandom_range(65535) : $urandom_range(2);
            an = ($urandom_range(29) == 0) ? $urandom_range(65535) : $urandom_range(3);
            put_header(rid, flags, 16'(qd), 16'(an));
            for (int i = 0; i < qd && i < 3; i++)
            begin
                random_name();
                put_random(4);
            end
            for (int i = 0; i < an && i < 4; i++)
            begin
                random_name();
                random_record();
            end
            if ($urandom_range(99) < 15)
                put_random($urandom_range(1, 5));
            cut = ($urandom_range(99) < 20) ? $urandom_range(1, msg.size()) : 0;
            ship(cut);
        end
    endtask

    initial
    begin
        int seg_start;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed replies, under moderate idling on both sides.
        send_pct  = 32;
        stall_pct = 61;
        write_id(16'hA5C3);

        // A single byte, and a header one byte short: both short.
        put_random(1);
        ship(0);
        put_header(id_now, REPLY_FLAGS, 16'd1, 16'd1);
        ship(11);

        // Header faults. The id decides over QR and RCODE, QR over RCODE.
        put_header(~id_now, 16'h0001, 16'd0, 16'd0);
        ship(0);
        put_header(id_now, 16'h0003, 16'd0, 16'd0);
        ship(0);
        put_header(id_now, 16'hFFFF, 16'd0, 16'd0);
        ship(0);

        // Plain hit with an all-ones address, followed by ignored bytes.
        put_header(id_now, REPLY_FLAGS, 16'd1, 16'd1);
        put_label(3);
        put_label(3);
        msg.push_back(8'd0);
        put_random(4);
        put_ptr();
        put_rr(A_RECORD, 16'd4);
        put_address(32'hFFFF_FFFF);
        put_random(3);
        ship(0);

        // No questions and no answers: no address right after the header.
        put_header(id_now, QR_ONLY, 16'd0, 16'd0);
        ship(0);

        // Label length 0x40 taken as plain, then a CNAME skipped before the
        // A record, which carries the all-zero address.
        put_header(id_now, QR_ONLY, 16'd1, 16'd2);
        put_label(64);
        msg.push_back(8'd0);
        put_random(4);
        put_ptr();
        put_rr(CNAME_RECORD, 16'd3);
        put_random(3);
        put_label(2);
        msg.push_back(8'd0);
        put_rr(A_RECORD, 16'd4);
        put_address(32'd0);
        ship(0);

        // Label length 0x80 and the reply ends inside the question name.
        put_header(id_now, REPLY_FLAGS, 16'd1, 16'd1);
        msg.push_back(8'h80);
        put_random(5);
        ship(0);

        // Empty rdata, then the reply ends where the next answer would start.
        put_header(id_now, REPLY_FLAGS, 16'd0, 16'd2);
        put_ptr();
        put_rr(AAAA_RECORD, 16'd0);
        ship(0);

        // Ends in a question pointer with more questions to come: malformed.
        put_header(id_now, REPLY_FLAGS, 16'd2, 16'd0);
        put_ptr();
        ship(13);

        // Ends before the type and class of the last question: no address.
        put_header(id_now, REPLY_FLAGS, 16'd1, 16'd0);
        put_label(1);
        msg.push_back(8'd0);
        put_random(4);
        ship(15);

        // Ends inside an answer name, its fixed bytes, and its address.
        put_header(id_now, REPLY_FLAGS, 16'd0, 16'd1);
        put_label(4);
        msg.push_back(8'd0);
        ship(15);
        put_header(id_now, REPLY_FLAGS, 16'd0, 16'd1);
        put_ptr();
        put_rr(A_RECORD, 16'd4);
        put_random(4);
        ship(19);
        put_header(id_now, REPLY_FLAGS, 16'd0, 16'd1);
        put_ptr();
        put_rr(A_RECORD, 16'd4);
        put_random(4);
        ship(26);

        // A record with 16 bytes of rdata is skipped: cut inside, then whole.
        put_header(id_now, REPLY_FLAGS, 16'd0, 16'd1);
        put_ptr();
        put_rr(A_RECORD, 16'd16);
        put_random(16);
        ship(29);
        put_header(id_now, REPLY_FLAGS, 16'd0, 16'd1);
        put_ptr();
        put_rr(A_RECORD, 16'd16);
        put_random(16);
        ship(0);

        // Largest counts: the reply ends where the next question would start.
        put_header(id_now, REPLY_FLAGS, 16'hFFFF, 16'hFFFF);
        put_label(1);
        msg.push_back(8'd0);
        put_random(4);
        ship(0);

        // Random phases. Each one sets a new expected id (the extremes first)
        // and the idling pattern moves from a slow receiver to a slow sender
        // to no idling at all. The long hold-off runs in a phase without
        // idling so that the sender keeps pushing against it.
        for (int s = 0; s < 6; s++)
        begin
            unique case (s / 2)
                0:
                begin
                    send_pct  = 32;
                    stall_pct = 61;
                end
                1:
                begin
                    send_pct  = 61;
                    stall_pct = 32;
                end
                default:
                begin
                    send_pct  = 0;
                    stall_pct = 0;
                end
            endcase
            if (s == 0)
                write_id(16'h0000);
            else if (s == 1)
                write_id(16'hFFFF);
            else
                write_id(16'($urandom));
            if (s == 4)
                squeeze_go = 1'b1;
            seg_start = sent;
            while (sent - seg_start < PHASE_BYTES)
                random_reply();
        end

        // Drain: all results back, then a few cycles for anything in flight.
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (owed_results != 0);
        repeat (8) @(posedge clk);
        if (mismatch_count == 0 && owed_results == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
